// File: rtl/core/ascp_pkg.sv
package ascp_pkg;

    typedef struct packed {
        logic       operation;
        logic [7:0] rx_byte;
    } cmd_t;

    typedef struct packed {
        logic [3:0]  action;
        logic [31:0] value;
        logic        extended_id;
        logic        remote_request;
        logic        self_receive;
        logic [3:0]  length_code;
        logic [63:0] payload;
        logic        last;
    } res_t;

    typedef enum logic [3:0] {
        ACT_ACK       = 4'd0,
        ACT_SERIAL    = 4'd1,
        ACT_VERSION   = 4'd2,
        ACT_STATUS    = 4'd3,
        ACT_SEND      = 4'd4,
        ACT_OPEN      = 4'd5,
        ACT_LOOPBACK  = 4'd6,
        ACT_LISTEN    = 4'd7,
        ACT_CLOSE     = 4'd8,
        ACT_BITRATE   = 4'd9,
        ACT_FILTER    = 4'd10,
        ACT_MASK      = 4'd11,
        ACT_TIMESTAMP = 4'd12
    } action_t;

    typedef enum logic [3:0] {
        K_NONE   = 4'd0,
        K_PLAIN  = 4'd1,
        K_SPEED  = 4'd2,
        K_VER    = 4'd3,
        K_SERIAL = 4'd4,
        K_STATUS = 4'd5,
        K_TSTAMP = 4'd6,
        K_FILTER = 4'd7,
        K_MASK   = 4'd8,
        K_DSTD   = 4'd9,
        K_DEXT   = 4'd10,
        K_RSTD   = 4'd11,
        K_REXT   = 4'd12,
        K_AUTO   = 4'd13
    } kind_t;

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_BODY   = 3'b010,
        PH_END    = 3'b100
    } phase_t;

    typedef enum logic [2:0] {
        FP_ID   = 3'b001,
        FP_LEN  = 3'b010,
        FP_DATA = 3'b100
    } fphase_t;

    localparam logic [7:0] CHR_CR       = 8'h0D;
    localparam logic [7:0] CHR_ZERO     = 8'h30;
    localparam logic [7:0] CHR_ONE      = 8'h31;
    localparam logic [7:0] CHR_UPPER_A  = 8'h41;
    localparam logic [7:0] CHR_LOWER_A  = 8'h61;

    localparam logic [7:0] CMD_OPEN     = 8'h4F; // O
    localparam logic [7:0] CMD_LOOP     = 8'h59; // Y
    localparam logic [7:0] CMD_LISTEN   = 8'h4C; // L
    localparam logic [7:0] CMD_CLOSE    = 8'h43; // C
    localparam logic [7:0] CMD_TS_LOW   = 8'h73; // s
    localparam logic [7:0] CMD_SPEED    = 8'h53; // S
    localparam logic [7:0] CMD_AUTO_LO  = 8'h61; // a
    localparam logic [7:0] CMD_AUTO_UP  = 8'h41; // A
    localparam logic [7:0] CMD_AUTO_D   = 8'h44; // D
    localparam logic [7:0] CMD_VER_LO   = 8'h76; // v
    localparam logic [7:0] CMD_VER_UP   = 8'h56; // V
    localparam logic [7:0] CMD_SERIAL   = 8'h4E; // N
    localparam logic [7:0] CMD_STATUS   = 8'h46; // F
    localparam logic [7:0] CMD_TSTAMP   = 8'h5A; // Z
    localparam logic [7:0] CMD_FILTER   = 8'h4D; // M
    localparam logic [7:0] CMD_MASK     = 8'h6D; // m
    localparam logic [7:0] CMD_DSTD     = 8'h74; // t
    localparam logic [7:0] CMD_DEXT     = 8'h54; // T
    localparam logic [7:0] CMD_RSTD     = 8'h72; // r
    localparam logic [7:0] CMD_REXT     = 8'h52; // R

    localparam logic [7:0]  MAX_BITRATE = 8'd8;
    localparam logic [31:0] STD_ID_MASK = 32'h0000_0FFF;
    localparam logic [4:0]  STD_ID_DIGITS = 5'd3;
    localparam logic [4:0]  EXT_ID_DIGITS = 5'd8;
    localparam logic [4:0]  WORD_DIGITS   = 5'd8;

endpackage

// File: rtl/core/ascii_can_command_parser.sv
// Serial-line CAN command parser. Each request carries one ASCII byte from the
// host link (or an idle-gap marker that resets the parser) and yields zero, one
// or two results: an immediate action (open, loopback, listen, close, bitrate,
// filter, mask, timestamp), or on carriage return the reply kind, preceded by a
// send-frame result for a frame command. A byte is registered on acceptance and
// then decoded into a two-slot result register, once no result blocks it. One
// byte is taken every cycle while results drain; a byte that causes two results
// fills the second slot, so the next byte waits in the input register until
// that slot has moved to the head.
module ascii_can_command_parser (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  ascp_pkg::cmd_t cmd,
    output logic           res_valid,
    input  logic           res_stall,
    output ascp_pkg::res_t res
);
    import ascp_pkg::*;

    logic    in_valid_reg, in_valid_next;
    cmd_t    in_reg;
    logic    head_valid_reg, head_valid_next;
    res_t    head_reg, head_next;
    logic    second_valid_reg, second_valid_next;
    res_t    second_reg, second_next;

    phase_t  phase_reg, phase_next;
    kind_t   kind_reg, kind_next;
    fphase_t fphase_reg, fphase_next;
    logic [4:0]  count_reg, count_next;
    logic [31:0] acc_reg, acc_next;
    logic [3:0]  nibble_reg, nibble_next;
    logic [3:0]  length_reg, length_next;
    logic [63:0] data_reg, data_next;
    logic        loop_reg, loop_next;

    logic        fire;
    logic        cmd_take;
    logic [7:0]  b;
    logic [7:0]  v;
    logic [3:0]  nib;
    logic        ext;
    logic        rem;
    logic [4:0]  count_inc;
    logic [7:0]  data_byte;
    res_t        r0, r1;
    logic [1:0]  n_res;
    action_t     reply;

    function automatic res_t make_res(action_t act, logic [31:0] val);
        res_t r;
        r = '0;
        r.action = act;
        r.value  = val;
        r.last   = 1'b1;
        return r;
    endfunction

    assign fire      = in_valid_reg && !second_valid_reg && (!head_valid_reg || !res_stall);
    assign cmd_stall = in_valid_reg && !fire;
    assign cmd_take  = cmd_valid && !cmd_stall;

    assign res_valid = head_valid_reg;
    assign res       = head_reg;

    assign b = in_reg.rx_byte;
    always_comb
    begin
        if (b >= CHR_LOWER_A)
            v = b - CHR_LOWER_A + 8'd10;
        else if (b >= CHR_UPPER_A)
            v = b - CHR_UPPER_A + 8'd10;
        else
            v = b - CHR_ZERO;
    end
    assign nib       = v[3:0];
    assign ext       = (kind_reg == K_DEXT) || (kind_reg == K_REXT);
    assign rem       = (kind_reg == K_RSTD) || (kind_reg == K_REXT);
    assign count_inc = count_reg + 5'd1;
    assign data_byte = {nibble_reg, nib};

    always_comb
    begin
        phase_next  = phase_reg;
        kind_next   = kind_reg;
        fphase_next = fphase_reg;
        count_next  = count_reg;
        acc_next    = acc_reg;
        nibble_next = nibble_reg;
        length_next = length_reg;
        data_next   = data_reg;
        loop_next   = loop_reg;
        r0          = '0;
        r1          = '0;
        n_res       = 2'd0;
        reply       = ACT_ACK;

        if (in_reg.operation)
        begin
            phase_next  = PH_HEADER;
            kind_next   = K_NONE;
            fphase_next = FP_ID;
            count_next  = '0;
            acc_next    = '0;
            nibble_next = '0;
            length_next = '0;
            data_next   = '0;
        end
        else
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    // any recognized command byte starts a fresh command
                    phase_next  = PH_END;
                    fphase_next = FP_ID;
                    count_next  = '0;
                    acc_next    = '0;
                    nibble_next = '0;
                    length_next = '0;
                    data_next   = '0;
                    case (b)
                        CMD_OPEN:
                        begin
                            loop_next = 1'b0;
                            kind_next = K_PLAIN;
                            r0 = make_res(ACT_OPEN, '0);
                            n_res = 2'd1;
                        end
                        CMD_LOOP:
                        begin
                            loop_next = 1'b1;
                            kind_next = K_PLAIN;
                            r0 = make_res(ACT_LOOPBACK, '0);
                            n_res = 2'd1;
                        end
                        CMD_LISTEN:
                        begin
                            loop_next = 1'b0;
                            kind_next = K_PLAIN;
                            r0 = make_res(ACT_LISTEN, '0);
                            n_res = 2'd1;
                        end
                        CMD_CLOSE:
                        begin
                            kind_next = K_PLAIN;
                            r0 = make_res(ACT_CLOSE, '0);
                            n_res = 2'd1;
                        end
                        CMD_TS_LOW: kind_next = K_PLAIN;
                        CMD_SPEED:
                        begin
                            kind_next  = K_SPEED;
                            phase_next = PH_BODY;
                        end
                        CMD_AUTO_LO, CMD_AUTO_UP, CMD_AUTO_D:
                        begin
                            kind_next  = K_AUTO;
                            phase_next = PH_BODY;
                        end
                        CMD_VER_LO, CMD_VER_UP: kind_next = K_VER;
                        CMD_SERIAL: kind_next = K_SERIAL;
                        CMD_STATUS: kind_next = K_STATUS;
                        CMD_TSTAMP:
                        begin
                            kind_next  = K_TSTAMP;
                            phase_next = PH_BODY;
                        end
                        CMD_FILTER:
                        begin
                            kind_next  = K_FILTER;
                            phase_next = PH_BODY;
                        end
                        CMD_MASK:
                        begin
                            kind_next  = K_MASK;
                            phase_next = PH_BODY;
                        end
                        CMD_DSTD:
                        begin
                            kind_next  = K_DSTD;
                            phase_next = PH_BODY;
                        end
                        CMD_DEXT:
                        begin
                            kind_next  = K_DEXT;
                            phase_next = PH_BODY;
                        end
                        CMD_RSTD:
                        begin
                            kind_next  = K_RSTD;
                            phase_next = PH_BODY;
                        end
                        CMD_REXT:
                        begin
                            kind_next  = K_REXT;
                            phase_next = PH_BODY;
                        end
                        default:
                        begin
                            // unknown byte: leave the parser untouched
                            phase_next  = phase_reg;
                            fphase_next = fphase_reg;
                            count_next  = count_reg;
                            acc_next    = acc_reg;
                            nibble_next = nibble_reg;
                            length_next = length_reg;
                            data_next   = data_reg;
                        end
                    endcase
                end
                PH_BODY:
                begin
                    case (kind_reg)
                        K_SPEED:
                        begin
                            phase_next = PH_END;
                            if (v <= MAX_BITRATE)
                            begin
                                r0 = make_res(ACT_BITRATE, {24'd0, v});
                                n_res = 2'd1;
                            end
                        end
                        K_TSTAMP:
                        begin
                            phase_next = PH_END;
                            if (b == CHR_ZERO || b == CHR_ONE)
                            begin
                                r0 = make_res(ACT_TIMESTAMP, {31'd0, b == CHR_ONE});
                                n_res = 2'd1;
                            end
                        end
                        K_FILTER, K_MASK:
                        begin
                            acc_next   = {acc_reg[27:0], nib};
                            count_next = count_inc;
                            if (count_inc >= WORD_DIGITS)
                            begin
                                count_next = '0;
                                phase_next = PH_END;
                                r0 = make_res((kind_reg == K_FILTER) ? ACT_FILTER : ACT_MASK,
                                              {acc_reg[27:0], nib});
                                n_res = 2'd1;
                            end
                        end
                        K_DSTD, K_DEXT, K_RSTD, K_REXT:
                        begin
                            unique case (fphase_reg)
                                FP_ID:
                                begin
                                    acc_next   = {acc_reg[27:0], nib};
                                    count_next = count_inc;
                                    if (count_inc >= (ext ? EXT_ID_DIGITS : STD_ID_DIGITS))
                                    begin
                                        if (!ext)
                                            acc_next = {acc_reg[27:0], nib} & STD_ID_MASK;
                                        fphase_next = FP_LEN;
                                        count_next  = '0;
                                    end
                                end
                                FP_LEN:
                                begin
                                    length_next = nib;
                                    count_next  = '0;
                                    if (rem || nib == 4'd0)
                                    begin
                                        phase_next  = PH_END;
                                        fphase_next = FP_ID;
                                    end
                                    else
                                        fphase_next = FP_DATA;
                                end
                                FP_DATA:
                                begin
                                    if (!count_reg[0])
                                        nibble_next = nib;
                                    else if (!count_reg[4])
                                    begin
                                        for (int i = 0; i < 8; i++)
                                        begin
                                            if (count_reg[3:1] == 3'(i))
                                                data_next[i*8 +: 8] = data_reg[i*8 +: 8]
                                                                      | data_byte;
                                        end
                                    end
                                    count_next = count_inc;
                                    // bytes beyond eight are counted but dropped
                                    if (count_inc >= {length_reg, 1'b0})
                                    begin
                                        phase_next  = PH_END;
                                        fphase_next = FP_ID;
                                        count_next  = '0;
                                    end
                                end
                                default:
                                begin
                                    fphase_next = FP_ID;
                                end
                            endcase
                        end
                        default: phase_next = PH_END;
                    endcase
                end
                PH_END:
                begin
                    if (b == CHR_CR)
                    begin
                        if (kind_reg == K_SERIAL)
                            reply = ACT_SERIAL;
                        else if (kind_reg == K_VER)
                            reply = ACT_VERSION;
                        else if (kind_reg == K_STATUS)
                            reply = ACT_STATUS;
                        if (kind_reg == K_DSTD || kind_reg == K_DEXT ||
                            kind_reg == K_RSTD || kind_reg == K_REXT)
                        begin
                            r0 = make_res(ACT_SEND, acc_reg);
                            r0.extended_id    = ext;
                            r0.remote_request = rem;
                            r0.self_receive   = loop_reg;
                            r0.length_code    = length_reg;
                            r0.payload        = rem ? 64'd0 : data_reg;
                            r0.last           = 1'b0;
                            r1 = make_res(reply, '0);
                            n_res = 2'd2;
                        end
                        else
                        begin
                            r0 = make_res(reply, '0);
                            n_res = 2'd1;
                        end
                        phase_next  = PH_HEADER;
                        kind_next   = K_NONE;
                        fphase_next = FP_ID;
                        count_next  = '0;
                        acc_next    = '0;
                        nibble_next = '0;
                        length_next = '0;
                        data_next   = '0;
                    end
                end
                default:
                begin
                    phase_next  = PH_HEADER;
                    kind_next   = K_NONE;
                    fphase_next = FP_ID;
                    count_next  = '0;
                    acc_next    = '0;
                    nibble_next = '0;
                    length_next = '0;
                    data_next   = '0;
                end
            endcase
        end
    end

    // input register and result slots
    always_comb
    begin
        in_valid_next     = in_valid_reg;
        head_valid_next   = head_valid_reg;
        head_next         = head_reg;
        second_valid_next = second_valid_reg;
        second_next       = second_reg;
        if (fire)
            in_valid_next = 1'b0;
        if (cmd_take)
            in_valid_next = 1'b1;
        if (fire)
        begin
            head_valid_next   = (n_res != 2'd0);
            head_next         = r0;
            second_valid_next = (n_res == 2'd2);
            second_next       = r1;
        end
        else if (head_valid_reg && !res_stall)
        begin
            // advance the second result into the head slot
            head_valid_next   = second_valid_reg;
            head_next         = second_reg;
            second_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            head_valid_reg   <= 1'b0;
            second_valid_reg <= 1'b0;
            phase_reg        <= PH_HEADER;
            kind_reg         <= K_NONE;
            fphase_reg       <= FP_ID;
            count_reg        <= '0;
            acc_reg          <= '0;
            nibble_reg       <= '0;
            length_reg       <= '0;
            data_reg         <= '0;
            loop_reg         <= 1'b0;
        end
        else
        begin
            in_valid_reg     <= in_valid_next;
            head_valid_reg   <= head_valid_next;
            second_valid_reg <= second_valid_next;
            if (fire)
            begin
                phase_reg  <= phase_next;
                kind_reg   <= kind_next;
                fphase_reg <= fphase_next;
                count_reg  <= count_next;
                acc_reg    <= acc_next;
                nibble_reg <= nibble_next;
                length_reg <= length_next;
                data_reg   <= data_next;
                loop_reg   <= loop_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
            in_reg <= cmd;
        head_reg   <= head_next;
        second_reg <= second_next;
    end

    a_second_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        second_valid_reg |-> head_valid_reg)
        else $error("second result slot filled while head slot empty");

    a_send_followed: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.last) |-> second_valid_reg)
        else $error("non-final result without a queued reply");

    a_stall_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> (in_valid_reg && !fire))
        else $error("request stalled with no held byte");

endmodule
